[hdl/spp_pkg.sv]
package spp_pkg;

  localparam logic [15:0] CRC_POLY     = 16'h8005;
  localparam int          PARAM_BYTES  = 4;
  localparam logic [15:0] PARAM_OFFSET = 16'd9;
  localparam logic [15:0] LAST_SHORT   = 16'd9;   // index of the tenth byte
  localparam logic [15:0] IDX_ID       = 16'd4;
  localparam logic [15:0] IDX_LEN_LO   = 16'd5;
  localparam logic [15:0] IDX_LEN_HI   = 16'd6;
  localparam logic [15:0] IDX_ERR      = 16'd8;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_packet;
  } spp_in_t;

  typedef struct packed {
    logic [7:0]  dev_id;
    logic [7:0]  error_byte;
    logic [15:0] length_field;
    logic [31:0] param_value;
    logic [15:0] crc_received;
    logic [15:0] crc_computed;
    logic        crc_ok;
    logic        too_short;
  } spp_out_t;

  // MSB-first CRC-16 update over one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[hdl/status_packet_parser_crc16.sv]
// Status packet parser: takes one byte per transfer and, on the byte flagged
// end_of_packet, gives one result with id, length, error byte, up to four
// little-endian parameter bytes, the received CRC (last two bytes) and a
// CRC-16 (poly 0x8005, init 0) over the rest. A byte is taken every cycle;
// the input stalls only while a result waits and the output is stalled. The
// whole CRC update and field capture sit between the state registers and the
// result register, so the result appears in the cycle after the last byte.
module status_packet_parser_crc16
  import spp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  spp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output spp_out_t out_data
);

  logic [15:0] byte_index, byte_index_next;
  logic [15:0] crc_running, crc_running_next;
  logic [7:0]  held0, held0_next, held1, held1_next;
  logic [1:0]  held_count, held_count_next;
  logic [7:0]  id_seen, id_seen_next;
  logic [7:0]  error_seen, error_seen_next;
  logic [15:0] length_seen, length_seen_next;
  logic [31:0] param_accum, param_accum_next;

  logic        in_xfer;
  logic [15:0] n, count;
  logic [15:0] rx_crc;
  spp_out_t    res;

  assign in_stall = out_valid & out_stall;
  assign in_xfer  = in_valid & ~in_stall;

  always_comb begin
    byte_index_next  = byte_index;
    crc_running_next = crc_running;
    held0_next       = held0;
    held1_next       = held1;
    held_count_next  = held_count;
    id_seen_next     = id_seen;
    error_seen_next  = error_seen;
    length_seen_next = length_seen;
    param_accum_next = param_accum;
    n     = byte_index - PARAM_OFFSET;
    count = (length_seen >= 16'd4) ? length_seen - 16'd4 : 16'd0;

    // two-byte delay line: the byte leaving it enters the CRC
    if (held_count == 2'd2) begin
      crc_running_next = crc_byte(crc_running, held0);
      held0_next       = held1;
      held1_next       = in_data.rx_byte;
    end else begin
      if (held_count[0]) begin
        held1_next = in_data.rx_byte;
      end else begin
        held0_next = in_data.rx_byte;
      end
      held_count_next = held_count + 2'd1;
    end

    if (byte_index == IDX_ID) begin
      id_seen_next = in_data.rx_byte;
    end else if (byte_index == IDX_LEN_LO) begin
      length_seen_next[7:0] = in_data.rx_byte;
    end else if (byte_index == IDX_LEN_HI) begin
      length_seen_next[15:8] = in_data.rx_byte;
    end else if (byte_index == IDX_ERR) begin
      error_seen_next = in_data.rx_byte;
    end else if (byte_index >= PARAM_OFFSET) begin
      if (n < count && n < 16'(PARAM_BYTES) && n < 16'd4) begin
        param_accum_next[8*n[1:0] +: 8] = in_data.rx_byte;
      end
    end

    if (byte_index != 16'hFFFF) begin
      byte_index_next = byte_index + 16'd1;
    end

    if (held_count_next == 2'd2) begin
      rx_crc = {held1_next, held0_next};
    end else begin
      rx_crc = {held0_next, 8'h00};
    end

    res.dev_id       = id_seen_next;
    res.error_byte   = error_seen_next;
    res.length_field = length_seen_next;
    res.param_value  = param_accum_next;
    res.crc_received = rx_crc;
    res.crc_computed = crc_running_next;
    res.crc_ok       = (rx_crc == crc_running_next);
    res.too_short    = (byte_index <= LAST_SHORT);
  end

  always_ff @(posedge clk) begin
    if (rst || (in_xfer && in_data.end_of_packet)) begin
      byte_index  <= '0;
      crc_running <= '0;
      held0       <= '0;
      held1       <= '0;
      held_count  <= '0;
      id_seen     <= '0;
      error_seen  <= '0;
      length_seen <= '0;
      param_accum <= '0;
    end else if (in_xfer) begin
      byte_index  <= byte_index_next;
      crc_running <= crc_running_next;
      held0       <= held0_next;
      held1       <= held1_next;
      held_count  <= held_count_next;
      id_seen     <= id_seen_next;
      error_seen  <= error_seen_next;
      length_seen <= length_seen_next;
      param_accum <= param_accum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && in_data.end_of_packet) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_data.end_of_packet) begin
      out_data <= res;
    end
  end

`ifndef SYNTH
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && in_data.end_of_packet) |=> (byte_index == 16'd0 && held_count == 2'd0))
    else $error("state not cleared after last byte");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_xfer && in_data.end_of_packet))
    else $error("result without a last byte");

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    in_xfer |-> (held_count != 2'd3))
    else $error("delay line count out of range");

  a_crc_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.crc_ok == (out_data.crc_received == out_data.crc_computed)))
    else $error("crc_ok disagrees with CRC fields");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import spp_pkg::*;

  typedef struct {
    logic [7:0] b;
    logic       eop;
    logic       typed;
    spp_out_t   want;
  } plan_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  spp_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  spp_out_t out_data;

  // predictor state
  logic [15:0] rx_pos;
  logic [15:0] crc_acc;
  logic [7:0]  tail_bytes [2];
  logic [1:0]  tail_fill;
  logic [7:0]  id_cap;
  logic [7:0]  err_cap;
  logic [15:0] len_cap;
  logic [31:0] param_cap;

  spp_out_t    pending_status [$];
  plan_row_t   directed [$];
  logic [7:0]  frame [$];
  int unsigned bytes_sent = 0;
  int unsigned gap_pct = 0;
  int          mismatches = 0;
  logic        quiet = 1'b0;
  logic        hold_req = 1'b0;

  status_packet_parser_crc16 u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c = {c[14:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic void clear_parser();
    rx_pos = '0;
    crc_acc = '0;
    tail_bytes[0] = '0;
    tail_bytes[1] = '0;
    tail_fill = '0;
    id_cap = '0;
    err_cap = '0;
    len_cap = '0;
    param_cap = '0;
  endfunction

  // returns 1 when the byte closes a packet; res then holds the status
  function automatic logic parse_byte(input spp_in_t item, output spp_out_t res);
    logic [15:0] at;
    logic [15:0] rx_crc;
    int unsigned n;
    int unsigned cnt;
    at = rx_pos;
    res = '0;
    // last two bytes sit in a delay line; only the byte leaving it is CRCed
    if (tail_fill >= 2'd2) begin
      crc_acc = crc16_step(crc_acc, tail_bytes[0]);
      tail_bytes[0] = tail_bytes[1];
      tail_bytes[1] = item.rx_byte;
    end else begin
      tail_bytes[tail_fill[0]] = item.rx_byte;
      tail_fill = tail_fill + 2'd1;
    end
    if (at == IDX_ID) id_cap = item.rx_byte;
    else if (at == IDX_LEN_LO) len_cap[7:0] = item.rx_byte;
    else if (at == IDX_LEN_HI) len_cap[15:8] = item.rx_byte;
    else if (at == IDX_ERR) err_cap = item.rx_byte;
    else if (at >= PARAM_OFFSET) begin
      n = at - PARAM_OFFSET;
      cnt = (len_cap >= 16'd4) ? len_cap - 16'd4 : 0;
      if (n < cnt && n < PARAM_BYTES && n < 4)
        param_cap = param_cap | (32'(item.rx_byte) << (8 * n));
    end
    if (rx_pos != 16'hFFFF) rx_pos = rx_pos + 16'd1;
    if (!item.end_of_packet) return 1'b0;
    rx_crc = (tail_fill >= 2'd2) ? {tail_bytes[1], tail_bytes[0]} : {tail_bytes[0], 8'h00};
    res.dev_id = id_cap;
    res.error_byte = err_cap;
    res.length_field = len_cap;
    res.param_value = param_cap;
    res.crc_received = rx_crc;
    res.crc_computed = crc_acc;
    res.crc_ok = (rx_crc == crc_acc);
    res.too_short = (at <= LAST_SHORT);
    clear_parser();
    return 1'b1;
  endfunction

  function automatic void compare_status(input spp_out_t want, input spp_out_t got);
    if (got.dev_id !== want.dev_id) begin
      $error("dev_id: expected %0h, got %0h", want.dev_id, got.dev_id);
      mismatches++;
    end
    if (got.error_byte !== want.error_byte) begin
      $error("error_byte: expected %0h, got %0h", want.error_byte, got.error_byte);
      mismatches++;
    end
    if (got.length_field !== want.length_field) begin
      $error("length_field: expected %0h, got %0h", want.length_field, got.length_field);
      mismatches++;
    end
    if (got.param_value !== want.param_value) begin
      $error("param_value: expected %0h, got %0h", want.param_value, got.param_value);
      mismatches++;
    end
    if (got.crc_received !== want.crc_received) begin
      $error("crc_received: expected %0h, got %0h", want.crc_received, got.crc_received);
      mismatches++;
    end
    if (got.crc_computed !== want.crc_computed) begin
      $error("crc_computed: expected %0h, got %0h", want.crc_computed, got.crc_computed);
      mismatches++;
    end
    if (got.crc_ok !== want.crc_ok) begin
      $error("crc_ok: expected %0h, got %0h", want.crc_ok, got.crc_ok);
      mismatches++;
    end
    if (got.too_short !== want.too_short) begin
      $error("too_short: expected %0h, got %0h", want.too_short, got.too_short);
      mismatches++;
    end
  endfunction

  // put the current frame into the directed table; only the closing row may carry a
  // hand-written status
  function automatic void plan_frame(input logic typed, input spp_out_t want);
    plan_row_t row;
    foreach (frame[i]) begin
      row.b = frame[i];
      row.eop = (i == frame.size() - 1);
      row.typed = row.eop && typed;
      row.want = want;
      directed.push_back(row);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eop, input logic typed,
                           input spp_out_t want);
    spp_in_t  item;
    spp_out_t res;
    item.rx_byte = b;
    item.end_of_packet = eop;
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (parse_byte(item, res)) pending_status.push_back(typed ? want : res);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1, 1'b0, '0);
  endtask

  initial begin : stimulus
    int unsigned rnd_start;
    int unsigned pkt_no;
    int unsigned kind;
    int unsigned np;
    int unsigned pos;
    logic [15:0] crc;
    clear_parser();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // single- and two-byte packets: a lone byte lands in the high half of the CRC field
    frame = '{8'hA5};
    plan_frame(1'b1, '{8'h00, 8'h00, 16'h0000, 32'h0, 16'hA500, 16'h0000, 1'b0, 1'b1});
    frame = '{8'h00};
    plan_frame(1'b1, '{8'h00, 8'h00, 16'h0000, 32'h0, 16'h0000, 16'h0000, 1'b1, 1'b1});
    frame = '{8'hFF, 8'hFF};
    plan_frame(1'b1, '{8'h00, 8'h00, 16'h0000, 32'h0, 16'hFFFF, 16'h0000, 1'b0, 1'b1});
    // length far beyond the packet: the CRC bytes are taken as parameters
    frame = '{8'hFF, 8'hFF, 8'hFD, 8'h00, 8'hFE, 8'hFF, 8'hFF, 8'h55, 8'hFF, 8'h00, 8'hFF};
    plan_frame(1'b0, '0);
    // ten zero bytes: one short of the minimum, CRC of zeros is zero
    frame = {};
    repeat (10) frame.push_back(8'h00);
    plan_frame(1'b1, '{8'h00, 8'h00, 16'h0000, 32'h0, 16'h0000, 16'h0000, 1'b1, 1'b1});

    gap_pct = 20;
    foreach (directed[i]) send_byte(directed[i].b, directed[i].eop, directed[i].typed,
                                    directed[i].want);

    rnd_start = bytes_sent;
    pkt_no = 0;
    while (bytes_sent - rnd_start < 900) begin
      if (bytes_sent - rnd_start > 820) begin
        quiet = 1'b1;
        gap_pct = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        gap_pct = 0;
      end else begin
        gap_pct = $urandom_range(5, 40);
      end
      if (pkt_no == 15) hold_req = 1'b1;
      kind = $urandom_range(0, 9);
      frame = '{8'hFF, 8'hFF, 8'hFD, 8'h00};
      frame.push_back(8'($urandom_range(0, 255)));
      if (kind <= 7) begin
        np = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
        frame.push_back(8'(np + 4));
        frame.push_back(8'h00);
        frame.push_back(8'h55);
        frame.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h00);
        repeat (np) frame.push_back(8'($urandom_range(0, 255)));
        crc = '0;
        foreach (frame[j]) crc = crc16_step(crc, frame[j]);
        frame.push_back(crc[7:0]);
        frame.push_back(crc[15:8]);
        if (kind == 7) begin
          pos = $urandom_range(0, frame.size() - 1);
          frame[pos] = frame[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
      end else if (kind == 8) begin
        // pure noise, mostly short
        frame = {};
        repeat ($urandom_range(1, 14)) frame.push_back(8'($urandom_range(0, 255)));
      end else begin
        // header with arbitrary length field and arbitrary tail
        case ($urandom_range(0, 2))
          0: crc = 16'($urandom_range(0, 3));
          1: crc = 16'hFFFF;
          default: crc = 16'($urandom_range(0, 65535));
        endcase
        frame.push_back(crc[7:0]);
        frame.push_back(crc[15:8]);
        frame.push_back(8'($urandom_range(0, 255)));
        frame.push_back(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 12)) frame.push_back(8'($urandom_range(0, 255)));
      end
      send_frame();
      pkt_no++;
    end
    in_valid <= 1'b0;

    while (pending_status.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("status_packet_parser_crc16 test passed");
    end else begin
      $display("status_packet_parser_crc16 test failed");
    end
    $finish;
  end

  // output-side backpressure, including one long hold to fill the block
  initial begin : out_pacing
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_status.size() == 0) begin
        $error("status transfer with nothing pending");
        mismatches++;
      end else begin
        compare_status(pending_status.pop_front(), out_data);
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("status_packet_parser_crc16 test failed");
    $finish;
  end

endmodule
